[hw/rtl/htfd_pkg.sv]
// types, constants and the crc step shared by the frame decoder modules
`timescale 1ns / 1ps
`default_nettype none

package htfd_pkg;

	// position within the reply frame, counts bytes taken so far
	typedef enum logic [2:0] {
		POS_IDLE      = 3'd0,
		POS_HUM_HI    = 3'd1,
		POS_HUM_MID   = 3'd2,
		POS_HUM_LO    = 3'd3,
		POS_TEMP_MID  = 3'd4,
		POS_TEMP_LO   = 3'd5,
		POS_CRC       = 3'd6
	} pos_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_CAL_OFF = 2'd1,
		ST_CRC_BAD = 2'd2,
		ST_ZERO    = 2'd3
	} status_t;

	localparam int unsigned RAW_W      = 20;
	localparam int unsigned HUM_C_W    = 14;
	localparam int unsigned TEMP_C_W   = 15;
	localparam int unsigned HUM_SCALE  = 10000;
	localparam int unsigned TEMP_SCALE = 20000;
	localparam int unsigned TEMP_OFFSET = 5000;
	localparam int unsigned HUM_P_W    = RAW_W + 14;
	localparam int unsigned TEMP_P_W   = RAW_W + 15;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam int unsigned CAL_BIT = 3;

	// classified frame handed from front to back
	typedef struct packed {
		status_t            code;
		logic [RAW_W-1:0]   hum_raw;
		logic [RAW_W-1:0]   temp_raw;
	} res_t;

	// finished result
	typedef struct packed {
		logic signed [TEMP_C_W-1:0] temp_centi;
		logic [HUM_C_W-1:0]         hum_centi;
		logic [RAW_W-1:0]           temp_raw;
		logic [RAW_W-1:0]           hum_raw;
		status_t                    code;
	} out_t;

	// one byte through crc-8, msb first
	function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/htfd_front.sv]
// front end: takes frame bytes, runs the crc, builds the codes and classifies the frame
`timescale 1ns / 1ps
`default_nettype none

module htfd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sensor_type,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,
	input  wire logic          s_tuser,
	input  wire logic          q_full,
	output logic               push,
	output htfd_pkg::res_t     push_item
);

	htfd_pkg::pos_t pos_q, pos_d;
	logic [7:0] crc_q, crc_d;
	logic [7:0] status_q, status_d;
	logic [htfd_pkg::RAW_W-1:0] hum_q, hum_d, temp_q, temp_d;
	logic accept, emit, crc_bad;
	logic [7:0] crc_step;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign crc_step = htfd_pkg::crc_feed(crc_q, s_tdata);

	// next position
	always_comb begin
		pos_d = pos_q;
		if (accept) begin
			if (s_tuser) begin
				pos_d = htfd_pkg::POS_HUM_HI;
			end else begin
				unique case (pos_q)
					htfd_pkg::POS_HUM_HI:   pos_d = htfd_pkg::POS_HUM_MID;
					htfd_pkg::POS_HUM_MID:  pos_d = htfd_pkg::POS_HUM_LO;
					htfd_pkg::POS_HUM_LO:   pos_d = htfd_pkg::POS_TEMP_MID;
					htfd_pkg::POS_TEMP_MID: pos_d = htfd_pkg::POS_TEMP_LO;
					htfd_pkg::POS_TEMP_LO: begin
						pos_d = sensor_type ? htfd_pkg::POS_CRC : htfd_pkg::POS_IDLE;
					end
					default:                pos_d = htfd_pkg::POS_IDLE;
				endcase
			end
		end
	end

	// datapath and emit decision
	always_comb begin
		crc_d    = crc_q;
		status_d = status_q;
		hum_d    = hum_q;
		temp_d   = temp_q;
		emit     = 1'b0;
		crc_bad  = 1'b0;
		if (accept) begin
			if (s_tuser) begin
				status_d = s_tdata;
				crc_d    = htfd_pkg::crc_feed(htfd_pkg::CRC_INIT, s_tdata);
				hum_d    = '0;
				temp_d   = '0;
			end else begin
				unique case (pos_q)
					htfd_pkg::POS_HUM_HI: begin
						hum_d = {s_tdata, 12'd0};
						crc_d = crc_step;
					end
					htfd_pkg::POS_HUM_MID: begin
						hum_d = hum_q | {8'd0, s_tdata, 4'd0};
						crc_d = crc_step;
					end
					htfd_pkg::POS_HUM_LO: begin
						hum_d  = hum_q | {16'd0, s_tdata[7:4]};
						temp_d = {s_tdata[3:0], 16'd0};
						crc_d  = crc_step;
					end
					htfd_pkg::POS_TEMP_MID: begin
						temp_d = temp_q | {4'd0, s_tdata, 8'd0};
						crc_d  = crc_step;
					end
					htfd_pkg::POS_TEMP_LO: begin
						temp_d = temp_q | {12'd0, s_tdata};
						crc_d  = crc_step;
						emit   = !sensor_type;
					end
					htfd_pkg::POS_CRC: begin
						emit    = 1'b1;
						crc_bad = (crc_q != s_tdata);
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_comb begin
		push_item.hum_raw  = hum_d;
		push_item.temp_raw = temp_d;
		priority if (!status_q[htfd_pkg::CAL_BIT]) begin
			push_item.code = htfd_pkg::ST_CAL_OFF;
		end else if (crc_bad) begin
			push_item.code = htfd_pkg::ST_CRC_BAD;
		end else if (!sensor_type && (hum_d == '0 || temp_d == '0)) begin
			push_item.code = htfd_pkg::ST_ZERO;
		end else begin
			push_item.code = htfd_pkg::ST_OK;
		end
	end

	assign push = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= htfd_pkg::POS_IDLE;
			crc_q    <= htfd_pkg::CRC_INIT;
			status_q <= '0;
			hum_q    <= '0;
			temp_q   <= '0;
		end else begin
			pos_q    <= pos_d;
			crc_q    <= crc_d;
			status_q <= status_d;
			hum_q    <= hum_d;
			temp_q   <= temp_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/htfd_fifo.sv]
// short queue of classified frames between front and back
`timescale 1ns / 1ps
`default_nettype none

module htfd_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire htfd_pkg::res_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output htfd_pkg::res_t      head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	htfd_pkg::res_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count beyond depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("pop from empty queue");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_q == rd_q))
		else $error("pointers disagree on empty queue");
`endif

endmodule

`default_nettype wire

[hw/rtl/htfd_back.sv]
// back end: scales the raw codes and holds the result for the output side
`timescale 1ns / 1ps
`default_nettype none

module htfd_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire htfd_pkg::res_t q_item,
	output logic               pop,
	output logic               m_valid,
	input  wire logic          m_ready,
	output htfd_pkg::out_t     m_item
);

	logic valid_s1, valid_q, out_adv, ld_s1;
	htfd_pkg::res_t item_s1;
	logic [htfd_pkg::HUM_P_W-1:0]  hum_prod_s1;
	logic [htfd_pkg::TEMP_P_W-1:0] temp_prod_s1;
	logic [htfd_pkg::TEMP_C_W-1:0] temp_sc;
	htfd_pkg::out_t out_q;

	assign out_adv = !valid_q || m_ready;
	assign ld_s1   = !valid_s1 || out_adv;
	assign pop     = q_valid && ld_s1;

	assign temp_sc = temp_prod_s1[htfd_pkg::TEMP_P_W-1 -: htfd_pkg::TEMP_C_W];

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1      <= q_item;
			hum_prod_s1  <= htfd_pkg::HUM_P_W'(q_item.hum_raw)
				* htfd_pkg::HUM_P_W'(htfd_pkg::HUM_SCALE);
			temp_prod_s1 <= htfd_pkg::TEMP_P_W'(q_item.temp_raw)
				* htfd_pkg::TEMP_P_W'(htfd_pkg::TEMP_SCALE);
		end
		if (out_adv) begin
			out_q.code       <= item_s1.code;
			out_q.hum_raw    <= item_s1.hum_raw;
			out_q.temp_raw   <= item_s1.temp_raw;
			out_q.hum_centi  <= hum_prod_s1[htfd_pkg::HUM_P_W-1 -: htfd_pkg::HUM_C_W];
			out_q.temp_centi <= $signed(temp_sc
				- htfd_pkg::TEMP_C_W'(htfd_pkg::TEMP_OFFSET));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (ld_s1) begin
				valid_s1 <= q_valid;
			end
			if (out_adv) begin
				valid_q <= valid_s1;
			end
		end
	end

	assign m_valid = valid_q;
	assign m_item  = out_q;

endmodule

`default_nettype wire

[hw/rtl/humidity_temp_frame_decoder.sv]
// top level of the humidity and temperature reply frame decoder
`timescale 1ns / 1ps
`default_nettype none

// decodes the sensor's measurement reply one byte per item: a status byte (tuser high marks
// it and starts a new frame), five bytes carrying 20-bit humidity and temperature codes, and
// for sensor_type 1 a crc-8 byte (poly 0x31, init 0xff) checked over the first six bytes.
// one result per complete frame, with both raw codes, both values in hundredths and a status:
// 0 ok, 1 calibration bit clear, 2 crc mismatch, 3 zero reading (older type only).
// a byte is taken every cycle while the queue has room; the front end does the crc and
// field build in the accepting cycle, the back end multiplies in one stage and registers
// the result. the queue of QUEUE_DEPTH frames lets the byte side keep running while the
// result side stalls, until the queue fills. sensor_type is sampled as the sixth byte
// arrives; a start mark mid-frame drops the unfinished frame.
module humidity_temp_frame_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration: sensor_type
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_data,
	// frame bytes
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tuser,   // [0] first_byte
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [1:0] status_code, [21:2] humidity_raw, [41:22] temperature_raw,
	// [55:42] humidity_centi, [70:56] temperature_centi, [71] zero
	output logic [71:0]      m_tdata
);

	logic sensor_type_q;
	logic q_full, q_push, q_pop, q_not_empty;
	htfd_pkg::res_t push_item, head;
	htfd_pkg::out_t out_item;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_type_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			sensor_type_q <= cfg_data[0];
		end
	end

	// byte intake, crc and classification
	htfd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sensor_type (sensor_type_q),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.q_full      (q_full),
		.push        (q_push),
		.push_item   (push_item)
	);

	// decoupling queue
	htfd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	// scaling and output register
	htfd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_not_empty),
		.q_item  (head),
		.pop     (q_pop),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_item  (out_item)
	);

	// pack the result, status code in the lowest bits
	assign m_tdata = {1'b0, out_item.temp_centi, out_item.hum_centi,
		out_item.temp_raw, out_item.hum_raw, out_item.code};

endmodule

`default_nettype wire

[dv/humidity_temp_frame_decoder_tb.sv]
// testbench for the humidity and temperature reply frame decoder
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_tb;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 400;

	// one decoded measurement as the block should report it
	typedef struct {
		htfd_pkg::status_t                   code;
		logic [htfd_pkg::RAW_W-1:0]          hum_raw;
		logic [htfd_pkg::RAW_W-1:0]          temp_raw;
		logic [htfd_pkg::HUM_C_W-1:0]        hum_centi;
		logic signed [htfd_pkg::TEMP_C_W-1:0] temp_centi;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] rx_byte
	logic        s_tuser;    // [0] first_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;    // [1:0] status, [21:2] hum raw, [41:22] temp raw,
	                         // [55:42] hum centi, [70:56] temp centi, [71] zero

	// decoder state mirrored on the testbench side
	htfd_pkg::pos_t             frame_pos;
	logic [7:0]                 frame_crc;
	logic [7:0]                 frame_status;
	logic [htfd_pkg::RAW_W-1:0] hum_acc;
	logic [htfd_pkg::RAW_W-1:0] temp_acc;
	logic                       sensor_type;

	reading_t pending_readings[$];

	int fault_count;
	int cycle_count;
	int src_idle_pct;
	int sink_stall_pct;
	int sink_hold_left;

	humidity_temp_frame_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// crc-8, one bit at a time, msb first
	function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		logic       fb;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			fb = r[7] ^ b[i];
			r  = r << 1;
			if (fb) begin
				r = r ^ htfd_pkg::CRC_POLY;
			end
		end
		return r;
	endfunction

	// scaled values and status for the frame just completed
	function automatic reading_t finished_reading(input logic crc_bad);
		reading_t    r;
		longint      hum_scaled;
		longint      temp_scaled;
		r.hum_raw  = hum_acc;
		r.temp_raw = temp_acc;
		hum_scaled  = (longint'(hum_acc) * htfd_pkg::HUM_SCALE) >>> htfd_pkg::RAW_W;
		temp_scaled = ((longint'(temp_acc) * htfd_pkg::TEMP_SCALE) >>> htfd_pkg::RAW_W)
			- htfd_pkg::TEMP_OFFSET;
		r.hum_centi  = hum_scaled[htfd_pkg::HUM_C_W-1:0];
		r.temp_centi = temp_scaled[htfd_pkg::TEMP_C_W-1:0];
		if (!frame_status[htfd_pkg::CAL_BIT]) begin
			r.code = htfd_pkg::ST_CAL_OFF;
		end else if (crc_bad) begin
			r.code = htfd_pkg::ST_CRC_BAD;
		end else if (!sensor_type && (hum_acc == '0 || temp_acc == '0)) begin
			r.code = htfd_pkg::ST_ZERO;
		end else begin
			r.code = htfd_pkg::ST_OK;
		end
		return r;
	endfunction

	// advance the mirrored decoder by one accepted byte
	task automatic decode_byte(input logic [7:0] b, input logic first);
		if (first) begin
			frame_status = b;
			frame_crc    = crc8_step(htfd_pkg::CRC_INIT, b);
			hum_acc      = '0;
			temp_acc     = '0;
			frame_pos    = htfd_pkg::POS_HUM_HI;
		end else begin
			case (frame_pos)
				htfd_pkg::POS_HUM_HI: begin
					hum_acc   = {b, 12'h000};
					frame_crc = crc8_step(frame_crc, b);
					frame_pos = htfd_pkg::POS_HUM_MID;
				end
				htfd_pkg::POS_HUM_MID: begin
					hum_acc   = hum_acc | {8'h00, b, 4'h0};
					frame_crc = crc8_step(frame_crc, b);
					frame_pos = htfd_pkg::POS_HUM_LO;
				end
				htfd_pkg::POS_HUM_LO: begin
					hum_acc   = hum_acc | {16'h0000, b[7:4]};
					temp_acc  = {b[3:0], 16'h0000};
					frame_crc = crc8_step(frame_crc, b);
					frame_pos = htfd_pkg::POS_TEMP_MID;
				end
				htfd_pkg::POS_TEMP_MID: begin
					temp_acc  = temp_acc | {4'h0, b, 8'h00};
					frame_crc = crc8_step(frame_crc, b);
					frame_pos = htfd_pkg::POS_TEMP_LO;
				end
				htfd_pkg::POS_TEMP_LO: begin
					temp_acc  = temp_acc | {12'h000, b};
					frame_crc = crc8_step(frame_crc, b);
					// the type seen here decides where the frame ends
					if (!sensor_type) begin
						frame_pos = htfd_pkg::POS_IDLE;
						pending_readings.push_back(finished_reading(1'b0));
					end else begin
						frame_pos = htfd_pkg::POS_CRC;
					end
				end
				htfd_pkg::POS_CRC: begin
					frame_pos = htfd_pkg::POS_IDLE;
					pending_readings.push_back(finished_reading(frame_crc != b));
				end
				default: begin
					// stray byte with no frame open
					frame_pos = htfd_pkg::POS_IDLE;
				end
			endcase
		end
	endtask

	// offer one item, entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b, input logic first);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= first;
		do begin
			@(posedge clk);
		end while (!s_tready);
		decode_byte(b, first);
		@(negedge clk);
	endtask

	// status byte, five data bytes, optional crc byte, good or corrupted
	task automatic send_frame(input logic [7:0] st, input logic [39:0] body,
			input logic with_crc, input logic crc_ok);
		logic [7:0] c;
		c = crc8_step(htfd_pkg::CRC_INIT, st);
		send_byte(st, 1'b1);
		for (int i = 4; i >= 0; i--) begin
			c = crc8_step(c, body[i*8 +: 8]);
			send_byte(body[i*8 +: 8], 1'b0);
		end
		if (with_crc) begin
			send_byte(crc_ok ? c : c ^ 8'($urandom_range(1, 255)), 1'b0);
		end
	endtask

	// stop offering, wait for every outstanding reading, then let the pipe empty
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_readings.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_sensor_type(input logic value);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sensor_type = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// older type: stray byte, dropped frame, full-scale frame
	task automatic test_older_type();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_sensor_type(1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_frame(8'hFF, '1, 1'b0, 1'b1);
	endtask

	// newer type: calibration clear outranks crc, then a plain crc mismatch
	task automatic test_newer_type();
		write_sensor_type(1'b1);
		send_frame(8'hF7, {$urandom(), 8'($urandom_range(255))}, 1'b1, 1'b0);
		send_frame(8'h08, 40'h0, 1'b1, 1'b0);
	endtask

	// type switched while a frame is half way through
	task automatic test_type_change();
		logic [7:0] c;
		// switched to older before the sixth byte: ends there, zero reading flagged
		send_byte(8'h08, 1'b1);
		repeat (4) send_byte(8'h00, 1'b0);
		write_sensor_type(1'b0);
		send_byte(8'h00, 1'b0);
		// switched to older after the sixth byte: crc byte still awaited and checked,
		// zero reading judged by the type in force when it arrives
		write_sensor_type(1'b1);
		c = crc8_step(htfd_pkg::CRC_INIT, 8'h08);
		send_byte(8'h08, 1'b1);
		repeat (5) begin
			c = crc8_step(c, 8'h00);
			send_byte(8'h00, 1'b0);
		end
		write_sensor_type(1'b0);
		send_byte(c, 1'b0);
	endtask

	// result side held off long enough for the frame queue to fill and stall bytes
	task automatic test_backpressure();
		write_sensor_type(1'b1);
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		@(posedge clk);
		sink_hold_left = HOLD_CYCLES;
		@(negedge clk);
		repeat (15) begin
			send_frame(8'($urandom_range(255)) | 8'h08,
				{$urandom(), 8'($urandom_range(255))}, 1'b1, 1'b1);
		end
		// sender waits for every reading before going on
		settle_idle();
		repeat (3) begin
			send_frame(8'($urandom_range(255)), {$urandom(), 8'($urandom_range(255))},
				1'b1, 1'b1);
		end
	endtask

	// mostly well-formed frames with random content, some stray bytes and cut frames
	task automatic run_random_phase(input logic type_sel, input int idle_pct,
			input int stall_pct, input int n_items);
		int         sent;
		int         choice;
		int         cut_len;
		logic [7:0] st;
		logic [39:0] body;
		write_sensor_type(type_sel);
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		sent = 0;
		while (sent < n_items) begin
			choice = $urandom_range(99);
			st     = 8'($urandom_range(255));
			if ($urandom_range(99) < 85) begin
				st[htfd_pkg::CAL_BIT] = 1'b1;
			end
			body = {$urandom(), 8'($urandom_range(255))};
			case ($urandom_range(11))
				0: body[39:20] = '0;
				1: body[19:0]  = '0;
				2: body        = '1;
				default: ;
			endcase
			if (choice < 80) begin
				send_frame(st, body, type_sel, $urandom_range(99) < 85);
				sent += 6 + type_sel;
			end else if (choice < 90) begin
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
			end else begin
				// frame cut short, dropped by the next start mark unless stray bytes complete it first
				cut_len = $urandom_range(0, 4 + type_sel);
				send_byte(st, 1'b1);
				for (int i = 0; i < cut_len; i++) begin
					send_byte(body[(4-i)*8 +: 8], 1'b0);
				end
				sent += cut_len + 1;
			end
		end
	endtask

	// result side: random stalls, or a counted hold-off when one is asked for
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold_left > 0) begin
				m_tready <= 1'b0;
				sink_hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	function automatic void check_field(input string name, input longint want,
			input longint got);
		if (want != got) begin
			if (fault_count < 10) begin
				$display("mismatch %s: expected %0d got %0d", name, want, got);
			end
			fault_count++;
		end
	endfunction

	// every accepted result against the oldest outstanding reading
	always @(posedge clk) begin
		reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_readings.size() == 0) begin
				if (fault_count < 10) begin
					$display("unexpected result %h", m_tdata);
				end
				fault_count++;
			end else begin
				want = pending_readings.pop_front();
				check_field("status", want.code, m_tdata[1:0]);
				check_field("hum_raw", want.hum_raw, m_tdata[21:2]);
				check_field("temp_raw", want.temp_raw, m_tdata[41:22]);
				check_field("hum_centi", want.hum_centi, m_tdata[55:42]);
				check_field("temp_centi", want.temp_centi, $signed(m_tdata[70:56]));
				check_field("pad", 0, m_tdata[71]);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("humidity_temp_frame_decoder_tb NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = 8'h00;
		s_tuser        = 1'b0;
		fault_count    = 0;
		cycle_count    = 0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		sink_hold_left = 0;
		frame_pos      = htfd_pkg::POS_IDLE;
		frame_crc      = htfd_pkg::CRC_INIT;
		frame_status   = 8'h00;
		hum_acc        = '0;
		temp_acc       = '0;
		sensor_type    = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_older_type();
		test_newer_type();
		test_type_change();
		test_backpressure();
		run_random_phase(1'b0, 0, 0, 210);
		run_random_phase(1'b1, 69, 0, 210);
		run_random_phase(1'b0, 0, 69, 210);
		run_random_phase(1'b1, 7, 7, 210);

		settle_idle();
		fault_count += pending_readings.size();
		if (fault_count == 0) begin
			$display("humidity_temp_frame_decoder_tb OK");
		end else begin
			$display("humidity_temp_frame_decoder_tb NOT OK");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_front.sv
hw/rtl/htfd_fifo.sv
hw/rtl/htfd_back.sv
hw/rtl/humidity_temp_frame_decoder.sv
dv/humidity_temp_frame_decoder_tb.sv
